### rtl/core/fcca_pkg.sv
// shared types and constants of the cluster chain allocator
package fcca_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 4096;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CNT_W   = 13;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned LOW_W   = 28;
	localparam int unsigned TOP_W   = WORD_W - LOW_W;

	localparam int unsigned REG_W    = 13;
	localparam int unsigned REGIDX_W = 2;

	localparam int unsigned IN_BITS  = CMD_W + IDX_W + 2 * WORD_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = STAT_W + IDX_W + CNT_W + WORD_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STAT_W-1:0]   stat_t;
	typedef logic [REGIDX_W-1:0] reg_idx_t;

	localparam cmd_t CMD_WRITE = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_ALLOC = 2'd2;
	localparam cmd_t CMD_FIND  = 2'd3;

	localparam stat_t ST_OK      = 2'd0;
	localparam stat_t ST_NOSPACE = 2'd1;
	localparam stat_t ST_NONE    = 2'd2;

	localparam reg_idx_t REG_ROOT    = 2'd0;
	localparam reg_idx_t REG_ENTRIES = 2'd1;
	localparam reg_idx_t REG_SHIFT   = 2'd2;

	localparam logic [IDX_W-1:0]   ROOT_RST    = 12'd2;
	localparam logic [CNT_W-1:0]   ENTRIES_RST = 13'd4096;
	localparam logic [SHIFT_W-1:0] SHIFT_RST   = 5'd12;

	localparam logic [LOW_W-1:0] END_MARK_LOW = 28'hFFFFFFF;

endpackage

### rtl/core/fcca_ram.sv
// generic single write port, single read port ram with registered read
module fcca_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/fat_cluster_chain_allocator_top.sv
// top level of the fat32 cluster chain allocator
//
// commands arrive as beats on the s_axis group and each gives exactly one
// result beat on the m_axis group. find first free scans the window from
// root_cluster+1 upward, one entry per cycle through the table ram read
// port, and answers with the first free entry, or with a no space status
// when nothing is free. allocate scans twice at one entry per cycle: a count
// pass that stops once enough free entries are seen, then a link pass that
// links each claimed entry to the next through the ram write port; a tail
// step then writes the end mark into the last claimed entry.
// a new command is taken while the previous result still sits in the
// output register; if the receiver stalls, the block holds the next finished
// result and takes no further command until the output register frees.
// after reset the table ram is swept to zero, one entry per cycle, over all
// TABLE_DEPTH entries; s_axis_tready stays low during the sweep.
// configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, the block does not enforce this.
module fat_cluster_chain_allocator_top #(
	parameter int unsigned TABLE_DEPTH = fcca_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fcca_pkg::REGIDX_W-1:0]  cfg_index,
	input  logic [fcca_pkg::REG_W-1:0]     cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// cmd, entry_index, entry_value, byte_count
	input  logic [fcca_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status, first_cluster, cluster_count, read_data
	output logic [fcca_pkg::OUT_W-1:0]     m_axis_tdata
);
	import fcca_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_FIND  = 3'd3;
	localparam logic [2:0] S_COUNT = 3'd4;
	localparam logic [2:0] S_LINK  = 3'd5;
	localparam logic [2:0] S_TAIL  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   root_q;
	logic [CNT_W-1:0]   entries_q;
	logic [SHIFT_W-1:0] shift_q;

	logic [SW-1:0]      ptr_q;
	logic               rd_vld_s1;
	logic [SW-1:0]      rd_idx_s1;
	logic [SW-1:0]      avail_q;
	logic [SW-1:0]      taken_q;
	logic [SW-1:0]      prev_q;
	logic [TOP_W-1:0]   prev_top_q;
	logic [SW-1:0]      head_q;
	logic [WORD_W-1:0]  need_q;
	logic               rd_oob_q;

	logic [STAT_W-1:0]  res_status_q;
	logic [IDX_W-1:0]   res_first_q;
	logic [CNT_W-1:0]   res_count_q;
	logic [WORD_W-1:0]  res_data_q;

	logic               out_vld_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [IDX_W-1:0]   out_first_q;
	logic [CNT_W-1:0]   out_count_q;
	logic [WORD_W-1:0]  out_data_q;

	cmd_t               in_cmd;
	logic [IDX_W-1:0]   in_idx;
	logic [WORD_W-1:0]  in_value;
	logic [WORD_W-1:0]  in_bytes;
	logic               accept;

	logic [SW-1:0]      lo;
	logic [SW-1:0]      hi;
	logic [SW-1:0]      idx_ext;
	logic               idx_ok;
	logic [WORD_W-1:0]  need;
	logic [WORD_W-1:0]  rem_mask;
	logic               scan_st;
	logic               issue;
	logic               hit;
	logic [SW-1:0]      avail_nx;
	logic [SW-1:0]      taken_nx;
	logic               scan_stop;
	logic               out_load;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [WORD_W-1:0]  mem_rdata;

	assign in_cmd   = s_axis_tdata[CMD_W-1:0];
	assign in_idx   = s_axis_tdata[CMD_W +: IDX_W];
	assign in_value = s_axis_tdata[CMD_W+IDX_W +: WORD_W];
	assign in_bytes = s_axis_tdata[CMD_W+IDX_W+WORD_W +: WORD_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign lo      = SW'(root_q) + SW'(1);
	assign hi      = (SW'(entries_q) < SW'(TABLE_DEPTH)) ? SW'(entries_q) : SW'(TABLE_DEPTH);
	assign idx_ext = SW'(in_idx);
	assign idx_ok  = idx_ext < SW'(TABLE_DEPTH);

	assign rem_mask = ~({WORD_W{1'b1}} << shift_q);
	assign need     = (in_bytes >> shift_q) + WORD_W'((in_bytes & rem_mask) != '0);

	assign scan_st  = (state_q == S_FIND) || (state_q == S_COUNT) || (state_q == S_LINK);
	assign issue    = scan_st && (ptr_q < hi);
	assign hit      = rd_vld_s1 && (mem_rdata[LOW_W-1:0] == '0);
	assign avail_nx = avail_q + SW'(hit);
	assign taken_nx = taken_q + SW'(1);

	// scan ends this cycle
	assign scan_stop = ((state_q == S_FIND) && hit)
		|| ((state_q == S_COUNT) && (WORD_W'(avail_nx) >= need_q))
		|| ((state_q == S_LINK) && hit && (WORD_W'(taken_nx) == need_q));

	assign out_load = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = '0;
		mem_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				mem_raddr = idx_ext[AW-1:0];
				mem_waddr = idx_ext[AW-1:0];
				mem_wdata = in_value;
				mem_we    = accept && (in_cmd == CMD_WRITE) && idx_ok;
			end
			S_LINK: begin
				mem_waddr = prev_q[AW-1:0];
				mem_wdata = {prev_top_q, LOW_W'(rd_idx_s1)};
				mem_we    = hit && (taken_q != '0);
			end
			S_TAIL: begin
				mem_waddr = prev_q[AW-1:0];
				mem_wdata = {prev_top_q, END_MARK_LOW};
				mem_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	fcca_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q    <= ROOT_RST;
			entries_q <= ENTRIES_RST;
			shift_q   <= SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROOT:    root_q    <= cfg_data[IDX_W-1:0];
				REG_ENTRIES: entries_q <= cfg_data[CNT_W-1:0];
				REG_SHIFT:   shift_q   <= cfg_data[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		if (accept) begin
			need_q   <= need;
			rd_oob_q <= !idx_ok;
		end
		if (state_q == S_LINK && hit) begin
			prev_q     <= rd_idx_s1;
			prev_top_q <= mem_rdata[WORD_W-1 -: TOP_W];
			if (taken_q == '0) begin
				head_q <= rd_idx_s1;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_first_q  <= res_first_q;
			out_count_q  <= res_count_q;
			out_data_q   <= res_data_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			avail_q      <= '0;
			taken_q      <= '0;
			out_vld_q    <= 1'b0;
			res_status_q <= ST_OK;
			res_first_q  <= '0;
			res_count_q  <= '0;
			res_data_q   <= '0;
		end else begin
			rd_vld_s1 <= issue && !scan_stop;
			if (issue && !scan_stop) begin
				ptr_q <= ptr_q + SW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (ptr_q == SW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + SW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_first_q  <= '0;
						res_count_q  <= '0;
						res_data_q   <= '0;
						ptr_q        <= lo;
						avail_q      <= '0;
						taken_q      <= '0;
						unique case (in_cmd)
							CMD_WRITE: state_q <= S_DONE;
							CMD_READ:  state_q <= S_READ;
							CMD_FIND:  state_q <= S_FIND;
							CMD_ALLOC: begin
								if (need == '0) begin
									res_status_q <= ST_NONE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_COUNT;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					res_data_q <= rd_oob_q ? '0 : mem_rdata;
					state_q    <= S_DONE;
				end
				S_FIND: begin
					if (hit) begin
						res_first_q <= rd_idx_s1[IDX_W-1:0];
						state_q     <= S_DONE;
					end else if (!issue && !rd_vld_s1) begin
						res_status_q <= ST_NOSPACE;
						state_q      <= S_DONE;
					end
				end
				S_COUNT: begin
					avail_q <= avail_nx;
					if (WORD_W'(avail_nx) >= need_q) begin
						ptr_q   <= lo;
						state_q <= S_LINK;
					end else if (!issue && !rd_vld_s1) begin
						res_status_q <= ST_NOSPACE;
						state_q      <= S_DONE;
					end
				end
				S_LINK: begin
					if (hit) begin
						taken_q <= taken_nx;
						if (WORD_W'(taken_nx) == need_q) begin
							state_q <= S_TAIL;
						end
					end
				end
				S_TAIL: begin
					res_first_q <= head_q[IDX_W-1:0];
					res_count_q <= need_q[CNT_W-1:0];
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}},
		out_data_q, out_count_q, out_first_q, out_status_q};

endmodule
